// ===== hdl/msfb_pkg.sv =====
// ---------------------------------------------------------------------------
// msfb_pkg: shared types and constants of the Modbus speed frame builder
// Drive-type codes, the queue entry type, frame byte tables and the CRC step.
// ---------------------------------------------------------------------------
package msfb_pkg;

   // drive-type register codes
   localparam logic [1:0] DRIVE_SINGLE_FA = 2'd0;
   localparam logic [1:0] DRIVE_SINGLE_20 = 2'd1;
   localparam logic [1:0] DRIVE_MULTI     = 2'd2;
   localparam logic [1:0] DRIVE_NONE      = 2'd3;

   localparam logic [15:0] CRC_START = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'hA001;

   // scaling by 16384/5000 = 2048/625 as floor((v * SCALE_MULT) >> SCALE_SHIFT),
   // exact for v below SCALE_LIMIT; at or above it the result saturates
   localparam int          SCALE_SHIFT = 25;
   localparam logic [26:0] SCALE_MULT  = 27'd109951163;
   localparam logic [15:0] SCALE_LIMIT = 16'd20000;

   localparam logic [3:0] LEN_SINGLE = 4'd6;
   localparam logic [3:0] LEN_MULTI  = 4'd11;

   typedef struct packed {
      logic [1:0]  drive;
      logic [15:0] word;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_head_type;

   function automatic logic [3:0] data_len(input logic [1:0] drive);
      return (drive == DRIVE_MULTI) ? LEN_MULTI : LEN_SINGLE;
   endfunction

   function automatic logic [7:0] data_byte(input logic [1:0] drive, input logic [3:0] idx,
                                            input logic [15:0] word);
      logic [7:0] b;
      b = 8'h00;
      if (drive == DRIVE_MULTI) begin
         case (idx)
            4'd0:    b = 8'h01;
            4'd1:    b = 8'h10;
            4'd2:    b = 8'h00;
            4'd3:    b = 8'h63;
            4'd4:    b = 8'h00;
            4'd5:    b = 8'h02;
            4'd6:    b = 8'h04;
            4'd7:    b = 8'h04;
            4'd8:    b = 8'h7F;
            4'd9:    b = word[15:8];
            4'd10:   b = word[7:0];
            default: b = 8'h00;
         endcase
      end else begin
         case (idx)
            4'd0:    b = 8'h00;
            4'd1:    b = 8'h06;
            4'd2:    b = (drive == DRIVE_SINGLE_FA) ? 8'hFA : 8'h20;
            4'd3:    b = 8'h01;
            4'd4:    b = word[15:8];
            4'd5:    b = word[7:0];
            default: b = 8'h00;
         endcase
      end
      return b;
   endfunction

   // one byte of the reflected Modbus CRC-16
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== hdl/msfb_front.sv =====
// ---------------------------------------------------------------------------
// msfb_front: command intake
// Holds the drive-type register, classifies each command and scales it.
// ---------------------------------------------------------------------------
module msfb_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [1:0]                csr_write_data,
   input  logic                      req_push,
   input  logic                      req_full,
   input  logic [15:0]               req_freq_command,
   output logic                      enq_valid,
   output msfb_pkg::queue_entry_type enq_entry
);

   logic [1:0]  drive_type_ff;
   logic [1:0]  drive_type_in;
   logic [41:0] product;
   logic [15:0] scaled;

   assign drive_type_in = csr_write_enable ? csr_write_data : drive_type_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_type_ff <= msfb_pkg::DRIVE_SINGLE_FA;
      end else begin
         drive_type_ff <= drive_type_in;
      end
   end

   // reciprocal multiply; the queue entry registers the product
   assign product = {27'd0, req_freq_command[14:0]} * {15'd0, msfb_pkg::SCALE_MULT};

   always_comb begin
      if (req_freq_command >= msfb_pkg::SCALE_LIMIT) begin
         scaled = 16'hFFFF;
      end else begin
         scaled = product[msfb_pkg::SCALE_SHIFT +: 16];
      end
   end

   // drive type "none" is accepted but makes no frame
   assign enq_valid       = req_push && !req_full && (drive_type_ff != msfb_pkg::DRIVE_NONE);
   assign enq_entry.drive = drive_type_ff;
   assign enq_entry.word  = (drive_type_ff == msfb_pkg::DRIVE_MULTI) ? scaled : req_freq_command;

endmodule

// ===== hdl/msfb_queue.sv =====
// ---------------------------------------------------------------------------
// msfb_queue: command queue
// Short register queue between intake and serializer.
// ---------------------------------------------------------------------------
module msfb_queue #(
   parameter int DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enq_valid,
   input  msfb_pkg::queue_entry_type enq_entry,
   output logic                      full,
   input  logic                      deq,
   output msfb_pkg::queue_head_type  head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   msfb_pkg::queue_entry_type store_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_enq, do_deq;

   assign full   = (count_ff == FULL_CNT);
   assign do_enq = enq_valid && !full;
   assign do_deq = deq && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_enq) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_deq) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_enq && !do_deq) begin
         count_in = count_ff + 1'b1;
      end else if (do_deq && !do_enq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_enq) begin
         store_ff[wr_ptr_ff] <= enq_entry;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = store_ff[rd_ptr_ff];

endmodule

// ===== hdl/msfb_back.sv =====
// ---------------------------------------------------------------------------
// msfb_back: frame serializer
// Walks the head command's frame one byte a cycle while the output is not stalled, running the CRC alongside.
// ---------------------------------------------------------------------------
module msfb_back (
   input  logic                     clock,
   input  logic                     reset,
   input  msfb_pkg::queue_head_type head,
   output logic                     deq,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [7:0]               rsp_frame_byte,
   output logic                     rsp_last_byte
);

   logic [3:0]  idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_last_ff, out_last_in;
   logic [3:0]  len;
   logic        advance;
   logic [7:0]  next_byte;
   logic        next_last;
   logic [15:0] next_crc;

   assign len     = msfb_pkg::data_len(head.entry.drive);
   assign advance = head.valid && (!out_valid_ff || rsp_pop);

   always_comb begin
      next_last = 1'b0;
      next_crc  = crc_ff;
      if (idx_ff < len) begin
         next_byte = msfb_pkg::data_byte(head.entry.drive, idx_ff, head.entry.word);
         next_crc  = msfb_pkg::crc_update(crc_ff, next_byte);
      end else if (idx_ff == len) begin
         next_byte = crc_ff[7:0];
      end else begin
         next_byte = crc_ff[15:8];
         next_last = 1'b1;
         next_crc  = msfb_pkg::CRC_START;
      end
   end

   always_comb begin
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         idx_in       = next_last ? 4'd0 : idx_ff + 4'd1;
         crc_in       = next_crc;
         out_valid_in = 1'b1;
         out_byte_in  = next_byte;
         out_last_in  = next_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 4'd0;
         crc_ff       <= msfb_pkg::CRC_START;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign deq            = advance && next_last;
   assign rsp_empty      = !out_valid_ff;
   assign rsp_frame_byte = out_byte_ff;
   assign rsp_last_byte  = out_last_ff;

endmodule

// ===== hdl/modbus_speed_frame_builder.sv =====
// ---------------------------------------------------------------------------
// modbus_speed_frame_builder: Modbus RTU speed write frame generator
// Turns a 16-bit frequency command into a CRC-terminated Modbus write frame.
// ---------------------------------------------------------------------------
// Usage:
//  - Input: queue-style push/full. Each accepted item is one freq_command.
//  - csr_write_enable/csr_write_data set the 2-bit drive type (reset 0):
//    0 -> 8-byte write to 0xFA01, 1 -> 8-byte write to 0x2001,
//    2 -> 13-byte multi write of the scaled value, 3 -> item dropped.
//    Write it only while no frame is pending.
//  - Output: queue-style empty/pop, one frame byte per item, rsp_last_byte
//    set on the CRC high byte.
//  - A command is registered in the queue, then its first byte in the output register.
//  - Output runs at one byte per cycle while rsp_pop keeps up, paced by
//    the serializer walking the frame through its single output register.
//  - A small command queue sits between intake and serializer; intake keeps
//    accepting until it fills (full raised), even while rsp_pop is low.
//  - A stalled output byte holds on the rsp_ ports until popped.
//  - Reset (synchronous) empties the queue and output, and drive type goes 0.
// ---------------------------------------------------------------------------
module modbus_speed_frame_builder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [15:0] req_freq_command,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_last_byte,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_write_data
);

   logic                      enq_valid;
   msfb_pkg::queue_entry_type enq_entry;
   msfb_pkg::queue_head_type  head;
   logic                      deq;

   // intake: drive-type register, classification, scaling
   msfb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_freq_command (req_freq_command),
      .enq_valid        (enq_valid),
      .enq_entry        (enq_entry)
   );

   // decouples intake from serializer
   msfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .enq_valid (enq_valid),
      .enq_entry (enq_entry),
      .full      (req_full),
      .deq       (deq),
      .head      (head)
   );

   // serializer: header bytes, payload, CRC low then high
   msfb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .deq            (deq),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule

// ===== hdl/msfb_checker.sv =====
// ---------------------------------------------------------------------------
// msfb_checker: port-level checks for the frame builder
// Watches the top-level ports; bound onto every instance of the top level.
// ---------------------------------------------------------------------------
module msfb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [7:0]  rsp_frame_byte,
   input logic        rsp_last_byte
);

   // reset leaves nothing to deliver
   a_reset_empty : assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending right after reset");

   // reset frees the intake
   a_reset_not_full : assert property (@(posedge clock) reset |=> !req_full)
      else $error("intake full right after reset");

   // a stalled byte holds
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_frame_byte) && $stable(rsp_last_byte)))
      else $error("stalled result changed");

   // a frame that follows another starts with a slave address byte of 0 or 1
   a_frame_start : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_last_byte) |=>
         (rsp_empty || rsp_frame_byte == 8'h00 || rsp_frame_byte == 8'h01))
      else $error("frame did not start with an address byte");

endmodule

bind modbus_speed_frame_builder msfb_checker u_msfb_checker (.*);
